FILE: rtl/core/tcp_pkg.sv
`timescale 1ns / 1ps

package tcp_pkg;

  typedef enum logic [2:0] {
    KIND_INIT      = 3'd0,
    KIND_SET_DEC   = 3'd1,
    KIND_SET_RA    = 3'd2,
    KIND_UNKNOWN   = 3'd3,
    KIND_MALFORMED = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    FORM_NONE = 2'd0,
    FORM_INIT = 2'd1,
    FORM_DEC  = 2'd2,
    FORM_RA   = 2'd3
  } form_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_command;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        command_kind;
    logic signed [7:0] first_value;
    logic signed [7:0] second_value;
    logic signed [7:0] third_value;
  } out_beat_t;

  // ASCII codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_I  = 8'h49;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_R  = 8'h72;

  localparam logic [3:0] POS_MAX = 4'd15;

endpackage

FILE: rtl/core/tcp_parser.sv
`timescale 1ns / 1ps

module tcp_parser import tcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_beat_t  beat_i,
  output logic      res_valid_o,
  output out_beat_t res_o
);

  logic [3:0] pos_q, pos_d;
  form_e      form_q, form_d;
  logic       failed_q, failed_d;
  logic       given_q, given_d;
  logic [1:0] field_q, field_d;
  logic [1:0] digits_q, digits_d;
  logic       neg_q, neg_d;
  logic       sign_q, sign_d;
  logic       fam_s_q, fam_s_d;
  logic [7:0] vals_q [3];
  logic [7:0] vals_d [3];

  logic [7:0] b;
  logic [7:0] expect_ch;
  logic [3:0] digit;
  logic [7:0] mag;
  logic       success;
  kind_e      succ_kind;

  assign b     = beat_i.data_byte;
  assign digit = 4'(b - CH_ZERO);
  // value*10 + digit; value is one digit here, so 8 bits hold it
  assign mag   = (vals_q[field_q] << 3) + (vals_q[field_q] << 1) + {4'd0, digit};

  always_comb begin
    case (field_q)
      2'd0:    expect_ch = (form_q == FORM_DEC) ? CH_STAR : CH_COLON;
      2'd1:    expect_ch = CH_COLON;
      default: expect_ch = CH_HASH;
    endcase
  end

  always_comb begin
    pos_d     = pos_q;
    form_d    = form_q;
    failed_d  = failed_q;
    given_d   = given_q;
    field_d   = field_q;
    digits_d  = digits_q;
    neg_d     = neg_q;
    sign_d    = sign_q;
    fam_s_d   = fam_s_q;
    vals_d    = vals_q;
    success   = 1'b0;
    succ_kind = KIND_INIT;

    if (!given_q) begin
      case (pos_q)
        4'd0: begin
          if (b != CH_COLON) failed_d = 1'b1;
        end
        4'd1: begin
          if (b == CH_UP_I)      form_d   = FORM_INIT;
          else if (b == CH_UP_S) fam_s_d  = 1'b1;
          else                   failed_d = 1'b1;
        end
        4'd2: begin
          if (form_q == FORM_INIT) begin
            if (!failed_q && b == CH_HASH) begin
              success   = 1'b1;
              succ_kind = KIND_INIT;
            end else begin
              failed_d = 1'b1;
            end
          end else if (fam_s_q && b == CH_LO_D) begin
            form_d = FORM_DEC;
          end else if (fam_s_q && b == CH_LO_R) begin
            form_d = FORM_RA;
          end else begin
            failed_d = 1'b1;
          end
        end
        default: begin
          if ((form_q == FORM_DEC || form_q == FORM_RA) && !failed_q) begin
            if (digits_q == 2'd2) begin
              // field complete, separator or terminator expected
              if (b != expect_ch) begin
                failed_d = 1'b1;
              end else if (field_q == 2'd2) begin
                success   = 1'b1;
                succ_kind = (form_q == FORM_DEC) ? KIND_SET_DEC : KIND_SET_RA;
              end else begin
                field_d  = field_q + 2'd1;
                digits_d = 2'd0;
                sign_d   = 1'b0;
                neg_d    = 1'b0;
              end
            end else if (digits_q == 2'd0 && !sign_q && (b inside {CH_PLUS, CH_MINUS})) begin
              sign_d = 1'b1;
              neg_d  = (b == CH_MINUS);
            end else if (b inside {[CH_ZERO:CH_NINE]}) begin
              if (digits_q == 2'd0) begin
                vals_d[field_q] = {4'd0, digit};
                digits_d        = 2'd1;
              end else begin
                vals_d[field_q] = neg_q ? 8'(8'd0 - mag) : mag;
                digits_d        = 2'd2;
              end
            end else begin
              failed_d = 1'b1;
            end
          end else begin
            failed_d = 1'b1;
          end
        end
      endcase
    end

    if (success) given_d = 1'b1;
    if (pos_q < POS_MAX) pos_d = pos_q + 4'd1;

    res_valid_o        = success;
    res_o.command_kind = succ_kind;
    res_o.first_value  = (success && succ_kind != KIND_INIT) ? vals_q[0] : 8'sd0;
    res_o.second_value = (success && succ_kind != KIND_INIT) ? vals_q[1] : 8'sd0;
    res_o.third_value  = (success && succ_kind != KIND_INIT) ? vals_q[2] : 8'sd0;

    if (beat_i.end_of_command) begin
      if (!given_d) begin
        res_valid_o        = 1'b1;
        res_o.command_kind = (form_d == FORM_NONE) ? KIND_UNKNOWN : KIND_MALFORMED;
      end
      pos_d    = 4'd0;
      form_d   = FORM_NONE;
      failed_d = 1'b0;
      given_d  = 1'b0;
      field_d  = 2'd0;
      digits_d = 2'd0;
      neg_d    = 1'b0;
      sign_d   = 1'b0;
      fam_s_d  = 1'b0;
      vals_d   = '{default: 8'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 4'd0;
      form_q   <= FORM_NONE;
      failed_q <= 1'b0;
      given_q  <= 1'b0;
      field_q  <= 2'd0;
      digits_q <= 2'd0;
      neg_q    <= 1'b0;
      sign_q   <= 1'b0;
      fam_s_q  <= 1'b0;
      vals_q   <= '{default: 8'd0};
    end else if (step_i) begin
      pos_q    <= pos_d;
      form_q   <= form_d;
      failed_q <= failed_d;
      given_q  <= given_d;
      field_q  <= field_d;
      digits_q <= digits_d;
      neg_q    <= neg_d;
      sign_q   <= sign_d;
      fam_s_q  <= fam_s_d;
      vals_q   <= vals_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && beat_i.end_of_command |=> pos_q == 4'd0 && !given_q && form_q == FORM_NONE)
    else $error("command state not cleared after last byte");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    given_q |-> !res_valid_o || (beat_i.end_of_command && 1'b0) || !res_valid_o)
    else $error("second result for one command");

  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_q != 2'd3 && digits_q != 2'd3)
    else $error("field counters out of range");

  a_fields_need_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (field_q != 2'd0 || digits_q != 2'd0) |-> (form_q == FORM_DEC || form_q == FORM_RA))
    else $error("field progress without a field form");

endmodule

FILE: rtl/core/telescope_command_parser.sv
`timescale 1ns / 1ps

// channel | dir | handshake                 | payload
// in      | in  | in_valid_i / in_stall_o   | in_beat_i  (data_byte, end_of_command)
// out     | out | out_valid_o / out_stall_i | out_beat_o (command_kind, three values)
//
// One byte per cycle while results can move; a taken byte waits in in_beat_q,
// is parsed from there, and its result, if any, is registered into out_beat_o.
// The parse state advances by one byte each time the held byte is parsed.
// Reset clears the parse state and both pipeline valids; no clearing pass.
// A stalled result holds the output register; the registered byte then waits
// only if it would produce a result, and in_stall_o rises once it cannot move.

module telescope_command_parser import tcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic      in_valid_q, in_valid_d;
  in_beat_t  in_beat_q;
  logic      out_valid_q, out_valid_d;
  out_beat_t out_beat_q;

  logic      res_valid;
  out_beat_t res;
  logic      out_free;
  logic      fire;
  logic      take;

  tcp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (fire),
    .beat_i      (in_beat_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && (!res_valid || out_free);
  assign in_stall_o = in_valid_q && !fire;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take)      in_valid_d = 1'b1;
    else if (fire) in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (fire && res_valid) out_valid_d = 1'b1;
    else if (out_free)     out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) in_beat_q <= in_beat_i;
    if (fire && res_valid) out_beat_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

FILE: dv/tcp_scoreboard_pkg.sv
`timescale 1ns / 1ps

package tcp_scoreboard_pkg;
  import tcp_pkg::*;

  class command_scoreboard;
    out_beat_t   pending_results[$];
    int unsigned errors;
    int unsigned kind_seen[5];

    // shadow parse state
    logic [3:0] byte_pos;
    form_e      form;
    bit         failed;
    bit         done;
    bit         s_family;
    bit         sign_seen;
    bit         neg;
    logic [1:0] fld_idx;
    logic [1:0] digits;
    logic [7:0] vals[3];

    function new();
      errors = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      byte_pos  = '0;
      form      = FORM_NONE;
      failed    = 1'b0;
      done      = 1'b0;
      s_family  = 1'b0;
      sign_seen = 1'b0;
      neg       = 1'b0;
      fld_idx   = '0;
      digits    = '0;
      foreach (vals[i]) vals[i] = '0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void push_expected(logic [2:0] kind, bit with_vals);
      out_beat_t r;
      r.command_kind = kind;
      r.first_value  = with_vals ? vals[0] : 8'sd0;
      r.second_value = with_vals ? vals[1] : 8'sd0;
      r.third_value  = with_vals ? vals[2] : 8'sd0;
      pending_results.insert(pending_results.size(), r);
    endfunction

    // one byte of the numeric part; 1 when the closing hash is taken
    function bit field_byte(logic [7:0] b);
      logic [7:0] sep;
      logic [7:0] mag;
      if (digits >= 2'd2) begin
        if (fld_idx == 2'd0) sep = (form == FORM_DEC) ? CH_STAR : CH_COLON;
        else if (fld_idx == 2'd1) sep = CH_COLON;
        else sep = CH_HASH;
        if (b != sep) begin
          failed = 1'b1;
          return 1'b0;
        end
        if (fld_idx == 2'd2) return 1'b1;
        fld_idx   = fld_idx + 2'd1;
        digits    = 2'd0;
        sign_seen = 1'b0;
        neg       = 1'b0;
        return 1'b0;
      end
      if (digits == 2'd0 && !sign_seen && (b == CH_PLUS || b == CH_MINUS)) begin
        sign_seen = 1'b1;
        neg       = (b == CH_MINUS);
        return 1'b0;
      end
      if (b >= CH_ZERO && b <= CH_NINE) begin
        if (digits == 2'd0) begin
          vals[fld_idx] = b - CH_ZERO;
          digits        = 2'd1;
        end else begin
          mag           = 8'(vals[fld_idx] * 10 + (b - CH_ZERO));
          vals[fld_idx] = neg ? 8'(8'd0 - mag) : mag;
          digits        = 2'd2;
        end
        return 1'b0;
      end
      failed = 1'b1;
      return 1'b0;
    endfunction

    function void take_byte(in_beat_t beat);
      logic [7:0] b;
      b = beat.data_byte;
      if (!done) begin
        case (byte_pos)
          4'd0: begin
            if (b != CH_COLON) failed = 1'b1;
          end
          4'd1: begin
            if (b == CH_UP_I) form = FORM_INIT;
            else if (b == CH_UP_S) s_family = 1'b1;
            else failed = 1'b1;
          end
          4'd2: begin
            if (form == FORM_INIT) begin
              if (!failed && b == CH_HASH) begin
                push_expected(KIND_INIT, 1'b0);
                done = 1'b1;
              end else begin
                failed = 1'b1;
              end
            end else if (s_family && b == CH_LO_D) begin
              form = FORM_DEC;
            end else if (s_family && b == CH_LO_R) begin
              form = FORM_RA;
            end else begin
              failed = 1'b1;
            end
          end
          default: begin
            if ((form == FORM_DEC || form == FORM_RA) && !failed) begin
              if (field_byte(b)) begin
                push_expected((form == FORM_DEC) ? KIND_SET_DEC : KIND_SET_RA, 1'b1);
                done = 1'b1;
              end
            end else begin
              failed = 1'b1;
            end
          end
        endcase
      end
      if (byte_pos != POS_MAX) byte_pos = byte_pos + 4'd1;
      if (beat.end_of_command) begin
        if (!done) push_expected((form == FORM_NONE) ? KIND_UNKNOWN : KIND_MALFORMED, 1'b0);
        clear_parse();
      end
    endfunction

    function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, $signed(want_v),
                 $signed(got_v));
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d values %0d %0d %0d",
                 $time, got.command_kind, got.first_value, got.second_value,
                 got.third_value);
        return;
      end
      want = pending_results.pop_front();
      kind_seen[want.command_kind]++;
      compare_field("command_kind", 8'(want.command_kind), 8'(got.command_kind));
      compare_field("first_value", want.first_value, got.first_value);
      compare_field("second_value", want.second_value, got.second_value);
      compare_field("third_value", want.third_value, got.third_value);
    endfunction
  endclass

endpackage

FILE: dv/telescope_command_parser_test.sv
`timescale 1ns / 1ps

module telescope_command_parser_test;
  import tcp_pkg::*;
  import tcp_scoreboard_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned TARGET_BYTES = 1260;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  command_scoreboard cmd_sb;
  bit          quiet     = 1'b0;
  bit          long_hold = 1'b0;
  int unsigned bytes_sent    = 0;
  int unsigned commands_sent = 0;
  logic [7:0]  cmd_bytes[$];

  telescope_command_parser u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    in_beat_t    beat;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    beat.data_byte      = b;
    beat.end_of_command = last;
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk); while (in_stall);
    cmd_sb.take_byte(in_beat);
    bytes_sent++;
  endtask

  task automatic send_command();
    for (int i = 0; i < cmd_bytes.size(); i++) send_byte(cmd_bytes[i], i == cmd_bytes.size() - 1);
    commands_sent++;
  endtask

  function automatic void append_byte(input logic [7:0] b);
    cmd_bytes.insert(cmd_bytes.size(), b);
  endfunction

  task automatic send_text(input string s);
    cmd_bytes.delete();
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    send_command();
  endtask

  // biased toward characters the parser looks at
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0:       return CH_COLON;
      1:       return CH_HASH;
      2:       return CH_STAR;
      3:       return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
      4, 5:    return 8'(CH_ZERO + $urandom_range(0, 9));
      6:       return $urandom_range(0, 1) ? CH_UP_I : CH_UP_S;
      7:       return $urandom_range(0, 1) ? CH_LO_D : CH_LO_R;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_field();
    case ($urandom_range(0, 2))
      1:       append_byte(CH_PLUS);
      2:       append_byte(CH_MINUS);
      default: ;
    endcase
    append_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    append_byte(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  // form_pick: 0 initialize, 1 declination, 2 right ascension
  task automatic build_good(input int form_pick, input int junk);
    cmd_bytes.delete();
    append_byte(CH_COLON);
    if (form_pick == 0) begin
      append_byte(CH_UP_I);
      append_byte(CH_HASH);
    end else begin
      append_byte(CH_UP_S);
      append_byte(form_pick == 1 ? CH_LO_D : CH_LO_R);
      add_field();
      append_byte(form_pick == 1 ? CH_STAR : CH_COLON);
      add_field();
      append_byte(CH_COLON);
      add_field();
      append_byte(CH_HASH);
    end
    repeat (junk) append_byte(pick_char());
  endtask

  task automatic mutate();
    int         idx;
    int         op;
    logic [7:0] tmp[$];
    idx = $urandom_range(0, cmd_bytes.size() - 1);
    op  = $urandom_range(0, 3);
    if (op == 0) begin
      cmd_bytes[idx] = pick_char();
    end else if (op == 1 && cmd_bytes.size() > 1) begin
      idx = $urandom_range(1, cmd_bytes.size() - 1);
      while (cmd_bytes.size() > idx) void'(cmd_bytes.pop_back());
    end else begin
      // insert before idx, or drop idx
      for (int i = 0; i < cmd_bytes.size(); i++) begin
        if (i == idx && op == 2) tmp.insert(tmp.size(), pick_char());
        if (!(i == idx && op == 3 && cmd_bytes.size() > 1)) tmp.insert(tmp.size(), cmd_bytes[i]);
      end
      cmd_bytes = tmp;
    end
  endtask

  task automatic build_noise();
    int unsigned len;
    len = $urandom_range(1, 20);
    cmd_bytes.delete();
    repeat (len) append_byte($urandom_range(0, 1) ? pick_char() : 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cmd_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result sink with random stall bursts and one long hold-off
  initial begin
    int unsigned n;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) cmd_sb.check_result(out_beat);
  end

  initial begin
    int unsigned still;
    still = 0;
    while (still < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) still = 0;
      else still++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, still);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int  r;
    bit  hold_done;
    bit  drain_done;
    cmd_sb     = new();
    hold_done  = 1'b0;
    drain_done = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_beat    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // directed: each form, value extremes, negative zero, early ends, bad selectors
    send_text(":I#");
    send_text(":Sd-99*+99:-00#");
    send_text(":Sr+05:-99:99#!");
    send_text(":I#:Sd");
    send_text("X");
    send_text(":Q#");
    send_text(":Sx");
    send_text(":S");
    send_text(":Sd5");
    send_text(":IX");
    send_text(":Sd+-1*00:00#");
    send_text(":Sr12*00:00#");
    cmd_bytes.delete();
    append_byte(8'hFF);
    append_byte(8'h00);
    send_command();

    while (bytes_sent < TARGET_BYTES) begin
      if (!hold_done && bytes_sent > 400) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && bytes_sent > 800) begin
        wait_results_drained();
        drain_done = 1'b1;
      end
      if (bytes_sent > 1080) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        build_good($urandom_range(0, 2), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);
      end else if (r < 85) begin
        build_good($urandom_range(0, 2), $urandom_range(0, 2));
        mutate();
        if ($urandom_range(0, 2) == 0) mutate();
      end else begin
        build_noise();
      end
      send_command();
    end

    wait_results_drained();
    $display("Drove %0d bytes in %0d commands, with a %0d-cycle output hold and a mid-run drain",
             bytes_sent, commands_sent, HOLD_CYCLES);
    $display("Checked results: init %0d, dec %0d, ra %0d, unknown %0d, malformed %0d",
             cmd_sb.kind_seen[KIND_INIT], cmd_sb.kind_seen[KIND_SET_DEC],
             cmd_sb.kind_seen[KIND_SET_RA], cmd_sb.kind_seen[KIND_UNKNOWN],
             cmd_sb.kind_seen[KIND_MALFORMED]);
    if (cmd_sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tcp_pkg.sv
rtl/core/tcp_parser.sv
rtl/core/telescope_command_parser.sv
dv/tcp_scoreboard_pkg.sv
dv/telescope_command_parser_test.sv
